@@ rtl/tdsm_pkg.sv @@
`default_nettype none
package tdsm_pkg;

  localparam int unsigned NumDigits = 3;

  typedef logic [3:0] code_t;

  localparam code_t CodeBlank = 4'd10;
  localparam code_t CodeMinus = 4'd11;

  localparam logic signed [15:0] ShowMax = 16'sd999;
  localparam logic signed [15:0] ShowMin = -16'sd99;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SHOW  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_POINT = 2'd3
  } kind_e;

  // one input item as held in the input register
  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] value;
    logic [1:0]         digit;
    logic               dp_on;
  } item_t;

  // current display drive
  typedef struct packed {
    logic [2:0] digit_enable;
    logic       point_out;
    logic [6:0] segments;
  } drive_t;

  // segment font, bit0 is A through bit6 is G
  function automatic logic [6:0] font(input code_t code);
    logic [6:0] seg;
    unique case (code)
      4'd0:      seg = 7'h3F;
      4'd1:      seg = 7'h06;
      4'd2:      seg = 7'h5B;
      4'd3:      seg = 7'h4F;
      4'd4:      seg = 7'h66;
      4'd5:      seg = 7'h6D;
      4'd6:      seg = 7'h7D;
      4'd7:      seg = 7'h07;
      4'd8:      seg = 7'h7F;
      4'd9:      seg = 7'h6F;
      CodeMinus: seg = 7'h40;
      default:   seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tdsm_digits.sv @@
`default_nettype none
module tdsm_digits (
  input  wire logic signed [15:0]         value_i,
  output tdsm_pkg::code_t [2:0]           codes_o
);
  import tdsm_pkg::*;

  logic signed [15:0] clamped;
  logic               neg;
  logic [15:0]        mag_full;
  logic [9:0]         mag;
  logic [15:0]        hund_prod;
  logic [17:0]        q10_prod;
  logic [3:0]         hund;
  logic [6:0]         q10;
  logic [6:0]         tens_w;
  logic [9:0]         ones_w;

  always_comb begin
    priority if (value_i > ShowMax) begin
      clamped = ShowMax;
    end else if (value_i < ShowMin) begin
      clamped = ShowMin;
    end else begin
      clamped = value_i;
    end
  end

  assign neg      = value_i[15];
  assign mag_full = neg ? 16'(-clamped) : 16'(clamped);
  assign mag      = mag_full[9:0];

  // reciprocal multiplies, exact for mag below 1000
  assign hund_prod = {6'd0, mag} * 16'd41;
  assign q10_prod  = {8'd0, mag} * 18'd205;
  assign hund      = hund_prod[15:12];
  assign q10       = q10_prod[17:11];
  assign tens_w    = q10 - ({3'd0, hund} * 7'd10);
  assign ones_w    = mag - ({3'd0, q10} * 10'd10);

  always_comb begin
    if (neg) begin
      codes_o[0] = CodeMinus;
    end else if (mag < 10'd100) begin
      codes_o[0] = CodeBlank;
    end else begin
      codes_o[0] = hund;
    end
    codes_o[1] = (mag < 10'd10) ? CodeBlank : tens_w[3:0];
    codes_o[2] = ones_w[3:0];
  end

endmodule
`default_nettype wire

@@ rtl/tdsm_core.sv @@
`default_nettype none
module tdsm_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire tdsm_pkg::item_t  item_i,
  input  wire logic [15:0]      period_i,
  output tdsm_pkg::drive_t      drive_o
);
  import tdsm_pkg::*;

  code_t [2:0] codes_q, codes_d;
  code_t [2:0] show_codes;
  logic [2:0]  points_q, points_d;
  logic [1:0]  scan_q, scan_d;
  logic [15:0] elapsed_q, elapsed_d;
  drive_t      drive_q, drive_d;
  logic [16:0] elapsed_inc;
  logic        step;

  tdsm_digits u_digits (
    .value_i (item_i.value),
    .codes_o (show_codes)
  );

  assign elapsed_inc = {1'b0, elapsed_q} + 17'd1;
  assign step        = elapsed_inc >= {1'b0, period_i};

  always_comb begin
    codes_d   = codes_q;
    points_d  = points_q;
    scan_d    = scan_q;
    elapsed_d = elapsed_q;
    drive_d   = drive_q;
    if (en_i) begin
      unique case (item_i.kind)
        KIND_TICK: begin
          if (step) begin
            elapsed_d             = '0;
            drive_d.segments      = font(codes_q[scan_q]);
            drive_d.point_out     = points_q[scan_q];
            drive_d.digit_enable  = 3'(1) << scan_q;
            scan_d                = (scan_q >= 2'(NumDigits - 1)) ? 2'd0 : scan_q + 2'd1;
          end else begin
            elapsed_d = elapsed_inc[15:0];
          end
        end
        KIND_SHOW: codes_d = show_codes;
        KIND_CLEAR: begin
          codes_d  = {NumDigits{CodeBlank}};
          points_d = '0;
        end
        KIND_POINT: begin
          if (item_i.digit < 2'(NumDigits)) begin
            points_d[item_i.digit] = item_i.dp_on;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q   <= {NumDigits{CodeBlank}};
      points_q  <= '0;
      scan_q    <= '0;
      elapsed_q <= '0;
      drive_q   <= '0;
    end else begin
      codes_q   <= codes_d;
      points_q  <= points_d;
      scan_q    <= scan_d;
      elapsed_q <= elapsed_d;
      drive_q   <= drive_d;
    end
  end

  assign drive_o = drive_q;

  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(drive_q.digit_enable))
    else $error("digit enable not one-hot");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q != 2'd3)
    else $error("scan position out of range");

  a_drive_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en_i || item_i.kind != KIND_TICK) |=> $stable(drive_q))
    else $error("drive changed without a tick");

  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.kind != KIND_TICK) |=> $stable(elapsed_q) && $stable(scan_q))
    else $error("non-tick item advanced the scan");

endmodule
`default_nettype wire

@@ rtl/three_digit_seven_segment_mux_top.sv @@
`default_nettype none
// three-digit multiplexed seven-segment display driver, common cathode
//
// s_axis: one item per handshake; tuser carries the kind (tick, show,
//   clear, set point), tdata carries value, digit and dp_on
// m_axis: exactly one item per input item, the drive after that item:
//   segments, decimal point and one-hot digit enable
// cfg: write of refresh_period (ticks per scan step), always ready;
//   write only while no item is in flight
//
// path: an accepted item passes two register stages (input, display
//   state) before its result is on m_axis
// throughput: one item per cycle, set by the single update of the
//   display state register; s_axis_tready drops only when both the input
//   register and the result register are full and m_axis stalls
// reset: digits blank, points off, scan at digit 0, tick count zero,
//   drive all dark, refresh_period 2
// stall: the result holds on m_axis; one more item is buffered in the
//   input register before s_axis backs up
module three_digit_seven_segment_mux_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // value[15:0], digit[17:16], dp_on[18], zero
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  // result items
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,  // segments[6:0], point_out[7], digit_enable[10:8], zero
  // configuration write
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [15:0] cfg_data_i      // refresh_period
);
  import tdsm_pkg::*;

  logic        in_valid_q;
  item_t       item_q;
  logic        out_valid_q;
  logic [15:0] period_q;
  logic        advance;
  drive_t      drive;

  // the display state register doubles as the result register, so it
  // only moves when the result slot is free or being taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      period_q    <= 16'd2;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        period_q <= cfg_data_i;
      end
    end
  end

  // payload of the input register, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.kind  <= kind_e'(s_axis_tuser);
      item_q.value <= s_axis_tdata[15:0];
      item_q.digit <= s_axis_tdata[17:16];
      item_q.dp_on <= s_axis_tdata[18];
    end
  end

  tdsm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item_q),
    .period_i (period_q),
    .drive_o  (drive)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, drive.digit_enable, drive.point_out, drive.segments};

endmodule
`default_nettype wire

@@ sim/display_scan_checker.sv @@
`timescale 1ns / 1ps
module display_scan_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // value[15:0], digit[17:16], dp_on[18], zero
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // segments[6:0], point_out[7], digit_enable[10:8], zero
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output int unsigned outstanding_o,
  output int unsigned fail_count_o
);
  import tdsm_pkg::*;

  localparam int unsigned ReportLimit = 10;

  // A..G per digit code, minus sign at code 11, everything else dark
  localparam logic [6:0] SegFont [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h00, 7'h40, 7'h00, 7'h00, 7'h00, 7'h00
  };

  code_t       shown_codes [NumDigits];
  logic        dp_flags    [NumDigits];
  logic [1:0]  scan_pos;
  logic [15:0] tick_count;
  logic [15:0] scan_period;
  drive_t      drive_now;
  drive_t      expected_drives [$];
  int unsigned result_count;
  int unsigned mismatches;

  always @(posedge clk_i) begin : watch
    kind_e              kind;
    logic signed [15:0] value;
    logic [1:0]         digit;
    logic [16:0]        next_count;
    int                 shown;
    int unsigned        mag;
    drive_t             want;
    drive_t             got;
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        shown_codes[i] = CodeBlank;
        dp_flags[i]    = 1'b0;
      end
      scan_pos     = '0;
      tick_count   = '0;
      scan_period  = 16'd2;
      drive_now    = '0;
      result_count = 0;
      mismatches   = 0;
      expected_drives.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        scan_period = cfg_data_i;
      end

      // results first: a result can never belong to an item taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.segments     = m_axis_tdata[6:0];
        got.point_out    = m_axis_tdata[7];
        got.digit_enable = m_axis_tdata[10:8];
        if (expected_drives.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("result %0d arrived with nothing expected: seg %h dp %b en %b",
                     result_count, got.segments, got.point_out, got.digit_enable);
          end
          mismatches++;
        end else begin
          want = expected_drives.pop_front();
          if (got.segments !== want.segments || got.point_out !== want.point_out ||
              got.digit_enable !== want.digit_enable) begin
            if (mismatches < ReportLimit) begin
              $display("result %0d: expected seg %h dp %b en %b, got seg %h dp %b en %b",
                       result_count, want.segments, want.point_out, want.digit_enable,
                       got.segments, got.point_out, got.digit_enable);
            end
            mismatches++;
          end
        end
        result_count++;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        kind  = kind_e'(s_axis_tuser);
        value = s_axis_tdata[15:0];
        digit = s_axis_tdata[17:16];
        case (kind)
          KIND_TICK: begin
            next_count = {1'b0, tick_count} + 17'd1;
            if (next_count < {1'b0, scan_period}) begin
              tick_count = next_count[15:0];
            end else begin
              // a zero period lands here on every tick as well
              tick_count = '0;
              if (scan_pos >= NumDigits) scan_pos = '0;
              drive_now.segments     = SegFont[shown_codes[scan_pos]];
              drive_now.point_out    = dp_flags[scan_pos];
              drive_now.digit_enable = 3'b001 << scan_pos;
              scan_pos = (scan_pos == 2'd2) ? 2'd0 : scan_pos + 2'd1;
            end
          end
          KIND_SHOW: begin
            shown = value;
            if (shown > int'(ShowMax)) shown = ShowMax;
            if (shown < int'(ShowMin)) shown = ShowMin;
            if (shown < 0) begin
              mag = -shown;
              shown_codes[0] = CodeMinus;
              shown_codes[1] = (mag < 10) ? CodeBlank : code_t'(mag / 10);
              shown_codes[2] = code_t'(mag % 10);
            end else begin
              mag = shown;
              shown_codes[0] = (mag < 100) ? CodeBlank : code_t'(mag / 100);
              shown_codes[1] = (mag < 10) ? CodeBlank : code_t'((mag / 10) % 10);
              shown_codes[2] = code_t'(mag % 10);
            end
          end
          KIND_CLEAR: begin
            for (int i = 0; i < NumDigits; i++) begin
              shown_codes[i] = CodeBlank;
              dp_flags[i]    = 1'b0;
            end
          end
          default: begin
            // position 3 does not exist and is dropped
            if (digit < NumDigits) dp_flags[digit] = s_axis_tdata[18];
          end
        endcase
        expected_drives.push_back(drive_now);
      end
    end
    outstanding_o <= expected_drives.size();
    fail_count_o  <= mismatches;
  end

endmodule

@@ sim/three_digit_seven_segment_mux_top_tb.sv @@
`timescale 1ns / 1ps
module three_digit_seven_segment_mux_top_tb;
  import tdsm_pkg::*;

  // far beyond the slowest legal run of 1625 items under heavy stalls
  localparam int unsigned CycleLimit   = 500000;
  // two register stages plus margin before a config write or the verdict
  localparam int unsigned SettleCycles = 4;

  // values around the clamp limits and the sign boundary
  localparam logic signed [15:0] EdgeValues [8] = '{
    16'sd999, 16'sd1000, -16'sd99, -16'sd100, 16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1
  };

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // value[15:0], digit[17:16], dp_on[18], zero
  logic [1:0]  s_axis_tuser;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // segments[6:0], point_out[7], digit_enable[10:8], zero
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 78;

  three_digit_seven_segment_mux_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // predicts the drive after every item and compares it with each result
  display_scan_checker scan_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure, rate set per phase
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hang guard
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // one item on s_axis; returns at the edge that accepts it with tvalid still high,
  // so back-to-back items keep tvalid up without a glitch
  task automatic send_item(input kind_e kind, input logic [15:0] value,
                           input logic [1:0] digit, input logic dp_on);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'd0, dp_on, digit, value};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and let every expected result come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    // outstanding is a registered copy of the checker queue size, so look only from the next edge on
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // random traffic at one refresh period; the block is drained before the write
  task automatic run_phase(input logic [15:0] period, input int unsigned count,
                           input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned roll;
    kind_e       kind;
    logic [15:0] value;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= period;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    // blocking so the first item of the phase already sees the new rates
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned n = 0; n < count; n++) begin
      // mid-phase hold-off until the pipe is empty
      if (n == count / 2) wait_drained();
      // ticks dominate so the scan moves through every position
      roll = $urandom_range(99);
      if (roll < 55) kind = KIND_TICK;
      else if (roll < 75) kind = KIND_SHOW;
      else if (roll < 80) kind = KIND_CLEAR;
      else kind = KIND_POINT;
      case ($urandom_range(3))
        0: value = 16'($urandom);
        1: value = 16'(int'($urandom_range(1120)) - 120);
        2: value = 16'(int'($urandom_range(24)) - 12);
        default: value = EdgeValues[$urandom_range(7)];
      endcase
      send_item(kind, value, 2'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_TICK;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset period of 2
    // first tick leaves the drive dark, nothing scanned yet
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);
    send_item(KIND_SHOW,  16'd999,    2'd0, 1'b0);
    send_item(KIND_POINT, 16'd0,      2'd0, 1'b1);
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);
    // clamping from above, including the largest field value
    send_item(KIND_SHOW,  16'd1000,   2'd0, 1'b0);
    send_item(KIND_SHOW,  16'h7FFF,   2'd0, 1'b0);
    // most negative field value clamps to -99
    send_item(KIND_SHOW,  16'h8000,   2'd0, 1'b0);
    // point on the nonexistent fourth position is dropped
    send_item(KIND_POINT, 16'd0,      2'd3, 1'b1);
    send_item(KIND_POINT, 16'd0,      2'd2, 1'b1);
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);
    send_item(KIND_SHOW,  -16'sd100,  2'd0, 1'b0);
    // single-digit negatives: minus, blank, digit
    send_item(KIND_SHOW,  -16'sd1,    2'd0, 1'b0);
    send_item(KIND_SHOW,  -16'sd9,    2'd0, 1'b0);
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);
    // zero shows blank, blank, 0
    send_item(KIND_SHOW,  16'd0,      2'd0, 1'b0);
    send_item(KIND_SHOW,  16'd5,      2'd0, 1'b0);
    send_item(KIND_SHOW,  16'd10,     2'd0, 1'b0);
    send_item(KIND_SHOW,  16'd100,    2'd0, 1'b0);
    send_item(KIND_POINT, 16'd0,      2'd1, 1'b1);
    send_item(KIND_POINT, 16'd0,      2'd1, 1'b0);
    send_item(KIND_CLEAR, 16'hFFFF,   2'd3, 1'b1);
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);
    send_item(KIND_TICK,  16'd0,      2'd0, 1'b0);

    // random part: zero period behaves like one, then the extremes and mid values
    run_phase(16'd0,     300, 34, 78);
    run_phase(16'd1,     300, 34, 78);
    run_phase(16'd3,     300, 78, 34);
    run_phase(16'hFFFF,  100, 78, 34);
    run_phase(16'($urandom_range(9, 4)), 300, 0, 0);
    run_phase(16'd2,     300, 0, 0);

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tdsm_pkg.sv
rtl/tdsm_digits.sv
rtl/tdsm_core.sv
rtl/three_digit_seven_segment_mux_top.sv
sim/display_scan_checker.sv
sim/three_digit_seven_segment_mux_top_tb.sv
